FILE: rtl/endpoint_failure_breaker_unit_defines.svh
// Assertion macros for the breaker RTL, used in efb_core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ENDPOINT_FAILURE_BREAKER_UNIT_DEFINES_SVH
`define ENDPOINT_FAILURE_BREAKER_UNIT_DEFINES_SVH

// same-cycle implication
`define EFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breaker assertion failed");

// next-cycle implication
`define EFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breaker assertion failed");

`endif

FILE: rtl/efb_pkg.sv
// Package for the endpoint failure breaker: action codes, register
// indexes, config and result structs, saturating arithmetic helpers.
package efb_pkg;

  localparam logic [1:0] ACT_CALL    = 2'd0;
  localparam logic [1:0] ACT_QUERY   = 2'd1;
  localparam logic [1:0] ACT_CONN    = 2'd2;
  localparam logic [1:0] ACT_TIMEOUT = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FAIL_SPAN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONSEC_FAIL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUTS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_Q8          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONN_ERRORS   = 3'd6;

  typedef struct packed {
    logic [15:0] window_interval;
    logic [15:0] min_fail_span;
    logic [15:0] consec_fail_limit;
    logic [15:0] min_timeouts;
    logic [8:0]  ratio_q8;
    logic [15:0] retry_interval;
    logic [7:0]  max_conn_errors;
  } cfg_t;

  typedef struct packed {
    logic is_active;
    logic may_send;
    logic just_disabled;
    logic just_enabled;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

endpackage

FILE: rtl/efb_if.sv
// Valid/ready channel interfaces for breaker transactions.
// Depends on nothing.
interface efb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_sec;
  logic        flag;
  modport source (output valid, action, now_sec, flag, input ready);
  modport sink   (input valid, action, now_sec, flag, output ready);
endinterface

interface efb_out_if;
  logic valid;
  logic ready;
  logic is_active;
  logic may_send;
  logic just_disabled;
  logic just_enabled;
  modport source (output valid, is_active, may_send, just_disabled, just_enabled,
                  input ready);
  modport sink   (input valid, is_active, may_send, just_disabled, just_enabled,
                  output ready);
endinterface

FILE: rtl/efb_cfg_regs.sv
// Configuration register file of the breaker, written through a plain port.
// Depends on efb_pkg.
module efb_cfg_regs
  import efb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  idx,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (idx)
        REG_WINDOW_INTERVAL:   cfg_nxt.window_interval   = wdata;
        REG_MIN_FAIL_SPAN:     cfg_nxt.min_fail_span     = wdata;
        REG_CONSEC_FAIL_LIMIT: cfg_nxt.consec_fail_limit = wdata;
        REG_MIN_TIMEOUTS:      cfg_nxt.min_timeouts      = wdata;
        REG_RATIO_Q8:          cfg_nxt.ratio_q8          = wdata[8:0];
        REG_RETRY_INTERVAL:    cfg_nxt.retry_interval    = wdata;
        REG_MAX_CONN_ERRORS:   cfg_nxt.max_conn_errors   = wdata[7:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_interval   <= 16'd60;
      cfg_r.min_fail_span     <= 16'd5;
      cfg_r.consec_fail_limit <= 16'd5;
      cfg_r.min_timeouts      <= 16'd2;
      cfg_r.ratio_q8          <= 9'd128;
      cfg_r.retry_interval    <= 16'd30;
      cfg_r.max_conn_errors   <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/efb_core.sv
// Breaker state registers and their combinational update for one transaction.
// Depends on efb_pkg and endpoint_failure_breaker_unit_defines.svh.
`include "endpoint_failure_breaker_unit_defines.svh"
module efb_core
  import efb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [1:0]  action,
  input  logic [31:0] now_sec,
  input  logic        flag,
  input  cfg_t        cfg,
  output result_t     res
);

  logic        active_r, active_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] failed_r, failed_nxt;
  logic [31:0] run_r, run_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [31:0] win_end_r, win_end_nxt;
  logic [31:0] retry_r, retry_nxt;
  logic        err_latch_r, err_latch_nxt;
  logic [7:0]  err_cnt_r, err_cnt_nxt;
  logic        tmo_latch_r, tmo_latch_nxt;

  logic [31:0] total_inc, failed_inc, run_inc, deadline_new, retry_arm;
  logic [7:0]  err_cnt_inc;
  logic [40:0] fail_scaled, thresh;
  logic        may;

  assign total_inc    = sat_inc(total_r);
  assign failed_inc   = sat_inc(failed_r);
  assign run_inc      = sat_inc(run_r);
  assign deadline_new = (run_r == 32'd0) ? sat_add(now_sec, cfg.min_fail_span) : deadline_r;
  assign retry_arm    = sat_add(now_sec, cfg.retry_interval);
  assign err_cnt_inc  = (err_cnt_r == 8'hFF) ? err_cnt_r : err_cnt_r + 8'd1;
  assign fail_scaled  = {1'b0, failed_inc, 8'd0};
  assign thresh       = {32'd0, cfg.ratio_q8} * {9'd0, total_inc};

  always_comb begin
    active_nxt    = active_r;
    total_nxt     = total_r;
    failed_nxt    = failed_r;
    run_nxt       = run_r;
    deadline_nxt  = deadline_r;
    win_end_nxt   = win_end_r;
    retry_nxt     = retry_r;
    err_latch_nxt = err_latch_r;
    err_cnt_nxt   = err_cnt_r;
    tmo_latch_nxt = tmo_latch_r;
    may           = 1'b0;
    case (action)
      ACT_CALL: begin
        if (!active_r) begin
          if (!flag) begin
            active_nxt    = 1'b1;
            run_nxt       = 32'd0;
            win_end_nxt   = sat_add(now_sec, cfg.window_interval);
            total_nxt     = 32'd1;
            failed_nxt    = 32'd0;
            tmo_latch_nxt = 1'b0;
            err_latch_nxt = 1'b0;
          end
        end else begin
          total_nxt = total_inc;
          if (flag) begin
            failed_nxt   = failed_inc;
            deadline_nxt = deadline_new;
            run_nxt      = run_inc;
          end else begin
            run_nxt = 32'd0;
          end
          if (flag && run_inc >= {16'd0, cfg.consec_fail_limit} &&
              now_sec >= deadline_new) begin
            active_nxt = 1'b0;
            retry_nxt  = retry_arm;
          end else if (now_sec > win_end_r) begin
            win_end_nxt = sat_add(now_sec, cfg.window_interval);
            if (flag && failed_inc >= {16'd0, cfg.min_timeouts} && fail_scaled >= thresh) begin
              active_nxt = 1'b0;
              retry_nxt  = retry_arm;
            end else begin
              total_nxt  = 32'd0;
              failed_nxt = 32'd0;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (active_r) begin
          may = 1'b1;
        end else if (now_sec >= retry_r) begin
          may       = 1'b1;
          retry_nxt = retry_arm;
        end
      end
      ACT_CONN: begin
        if (flag) begin
          if (!err_latch_r) begin
            err_cnt_nxt = err_cnt_inc;
            if (err_cnt_inc >= cfg.max_conn_errors) begin
              active_nxt    = 1'b0;
              retry_nxt     = retry_arm;
              err_latch_nxt = 1'b1;
            end
          end
        end else begin
          err_latch_nxt = 1'b0;
          err_cnt_nxt   = 8'd0;
          active_nxt    = 1'b1;
        end
      end
      default: begin
        if (flag != tmo_latch_r) begin
          tmo_latch_nxt = flag;
          if (flag) begin
            active_nxt = 1'b0;
            retry_nxt  = retry_arm;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b1;
      total_r     <= '0;
      failed_r    <= '0;
      run_r       <= '0;
      deadline_r  <= '0;
      win_end_r   <= '0;
      retry_r     <= '0;
      err_latch_r <= 1'b0;
      err_cnt_r   <= '0;
      tmo_latch_r <= 1'b0;
    end else if (step) begin
      active_r    <= active_nxt;
      total_r     <= total_nxt;
      failed_r    <= failed_nxt;
      run_r       <= run_nxt;
      deadline_r  <= deadline_nxt;
      win_end_r   <= win_end_nxt;
      retry_r     <= retry_nxt;
      err_latch_r <= err_latch_nxt;
      err_cnt_r   <= err_cnt_nxt;
      tmo_latch_r <= tmo_latch_nxt;
    end
  end

  assign res.is_active     = active_nxt;
  assign res.may_send      = may;
  assign res.just_disabled = active_r & ~active_nxt;
  assign res.just_enabled  = ~active_r & active_nxt;

  `EFB_ASSERT_NEXT(a_hold_when_idle, !step, $stable(active_r) && $stable(retry_r))
  `EFB_ASSERT_NEXT(a_disable_arms_retry, step && res.just_disabled,
                   !active_r && retry_r >= $past(now_sec))
  `EFB_ASSERT_NOW(a_active_may_send, step && action == ACT_QUERY && active_r, res.may_send)
  `EFB_ASSERT_NOW(a_query_keeps_state, step && action == ACT_QUERY,
                  !res.just_disabled && !res.just_enabled)

endmodule

FILE: rtl/endpoint_failure_breaker_unit.sv
// Endpoint failure breaker: takes one transaction per clock while the sink
// is not stalling and returns one result per transaction (the transaction
// lands in the input register at acceptance, and the breaker update writes
// the output register when the core steps); a stalled sink holds the result
// there. Sustained rate is one transaction per cycle while the sink is ready;
// the limit is the state update loop, whose longest path is the 9 x 32 bit
// failure-ratio multiply. Configuration writes belong in idle periods only.
module endpoint_failure_breaker_unit
  import efb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  efb_in_if.sink                in_if,
  efb_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg;
  result_t     res;
  logic        in_vld_r, out_vld_r;
  logic [1:0]  action_r;
  logic [31:0] now_r;
  logic        flag_r;
  result_t     out_r;
  logic        step;

  assign step         = in_vld_r & (~out_vld_r | out_if.ready);
  assign in_if.ready  = ~in_vld_r | step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_if.ready) in_vld_r <= in_if.valid;
      if (~out_vld_r | out_if.ready) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      action_r <= in_if.action;
      now_r    <= in_if.now_sec;
      flag_r   <= in_if.flag;
    end
    if (step) out_r <= res;
  end

  efb_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  efb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .action  (action_r),
    .now_sec (now_r),
    .flag    (flag_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_if.valid         = out_vld_r;
  assign out_if.is_active     = out_r.is_active;
  assign out_if.may_send      = out_r.may_send;
  assign out_if.just_disabled = out_r.just_disabled;
  assign out_if.just_enabled  = out_r.just_enabled;

endmodule
